/* hdl/audio_queue_health_monitor_unit_macros.svh */
// Assertion macros shared by the audio queue health monitor checker.
`ifndef AUDIO_QUEUE_HEALTH_MONITOR_UNIT_MACROS_SVH
`define AUDIO_QUEUE_HEALTH_MONITOR_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define AQHM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aqhm: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define AQHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aqhm: next-cycle check failed");

`endif

/* hdl/aqhm_pkg.sv */
// Types, constants and codes of the audio queue health monitor.
`default_nettype none

package aqhm_pkg;

  // Divider geometry: numerator is a 16-bit frame count times one million.
  localparam int NUM_W     = 36;
  localparam int DEN_W     = 18;
  localparam int DIV_CNT_W = 6;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_PERIOD = 2'd1;
  localparam int CFG_DATA_W = 18;

  localparam logic [17:0] RATE_RESET = 18'd48000;
  localparam logic [15:0] HOST_RESET = 16'd512;

  // Status flag bit positions.
  localparam int FLAG_EMPTY = 0;
  localparam int FLAG_BELOW = 1;
  localparam int FLAG_LATE  = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic [15:0]        fill_before;
    logic [15:0]        frame_count;
    logic signed [15:0] first_left;
    logic signed [15:0] first_right;
    logic signed [15:0] last_left;
    logic signed [15:0] last_right;
    logic [47:0]        time_us;
  } in_t;

  typedef struct packed {
    logic [31:0] sequence_res;
    logic [2:0]  status_flags;
    logic [31:0] gap_us;
    logic [22:0] expected_us;
    logic [15:0] seam_step;
    logic [31:0] empty_total;
    logic [31:0] below_total;
    logic [31:0] late_total;
    logic [15:0] fill_min;
    logic [15:0] fill_max;
    logic [31:0] gap_max;
    logic [15:0] seam_step_max;
  } out_t;

endpackage

`default_nettype wire

/* hdl/aqhm_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module aqhm_serial_div (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire [aqhm_pkg::NUM_W-1:0] num_i,
  input  wire [aqhm_pkg::DEN_W-1:0] den_i,
  output logic [aqhm_pkg::NUM_W-1:0] quo_o,
  output logic                     done_o
);
  import aqhm_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [NUM_W-1:0]     quo_q, quo_d;
  logic [DEN_W:0]       trial;
  logic                 fits;
  logic                 last_step;

  // Shift the next numerator bit into the partial remainder and try the subtract.
  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign fits      = trial >= {1'b0, den_q};
  assign last_step = busy_q && (cnt_q == DIV_CNT_W'(NUM_W - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  // Hold control state under reset; the datapath needs none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = last_step;

endmodule

`default_nettype wire

/* hdl/audio_queue_health_monitor_unit.sv */
// Top level of the audio queue health monitor.
//
//   channel   direction  handshake                 payload
//   in        request    in_valid_i / in_ready_o   in_data_i  (aqhm_pkg::in_t)
//   out       result     out_valid_o / out_ready_i out_data_o (aqhm_pkg::out_t)
//   cfg       write      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A request runs from acceptance to a loaded result through the steps of the
// two bit-serial dividers (expected play time and host period in us), a sum
// step and a finish step that builds the result and updates the statistics.
// The next request can be taken once the result sits in the output register,
// so no new request is taken while one is in flight.
// Reset is asynchronous, active low, and leaves the block idle with no result.
// A stalled result holds the finish step until the output register frees up.
`default_nettype none

module audio_queue_health_monitor_unit (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  aqhm_pkg::in_t                         in_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output aqhm_pkg::out_t                        out_data_o,
  input  wire                                   cfg_we_i,
  input  wire [aqhm_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire [aqhm_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import aqhm_pkg::*;

  // Absolute difference of two signed samples; always fits 16 bits.
  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    logic [16:0]        m;
    d = 17'(a) - 17'(b);
    m = d[16] ? 17'(-d) : 17'(d);
    return m[15:0];
  endfunction

  st_e state_q, state_d;

  // Configuration.
  logic [17:0] rate_q;
  logic [15:0] host_q;

  // Running state.
  logic [31:0]        submit_q;
  logic [15:0]        last_fc_q;
  logic [47:0]        last_time_q;
  logic               time_valid_q;
  logic signed [15:0] tail_left_q;
  logic signed [15:0] tail_right_q;
  logic               tail_valid_q;
  logic [31:0]        empty_cnt_q;
  logic [31:0]        below_cnt_q;
  logic [31:0]        late_cnt_q;
  logic [15:0]        min_fill_q;
  logic [15:0]        max_fill_q;
  logic [31:0]        max_gap_q;
  logic [15:0]        max_step_q;

  // Request in flight.
  in_t         item_q;
  logic [47:0] gap_q;
  logic        meas_q;
  logic [NUM_W:0] sum_q, sum_d;

  // Result register.
  logic out_valid_q;
  out_t out_q, out_d;

  // Control.
  logic in_take;
  logic div_start;
  logic out_load;

  // Divider lanes.
  logic [NUM_W-1:0] num_exp, num_host;
  logic [NUM_W-1:0] quo_exp, quo_host;
  logic             done_exp, done_host;

  assign num_exp  = NUM_W'(last_fc_q) * NUM_W'(US_PER_S);
  assign num_host = NUM_W'(host_q) * NUM_W'(US_PER_S);

  aqhm_serial_div u_div_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_exp),
    .den_i   (rate_q),
    .quo_o   (quo_exp),
    .done_o  (done_exp)
  );

  aqhm_serial_div u_div_host (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_host),
    .den_i   (rate_q),
    .quo_o   (quo_host),
    .done_o  (done_host)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_take) state_d = ST_DIV;
      ST_DIV:  if (done_exp && done_host) state_d = ST_SUM;
      ST_SUM:  state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DONE: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_take   = in_valid_i && in_ready_o;
  assign div_start = in_take;

  // Add the two quotients for the late test.
  assign sum_d = {1'b0, quo_exp} + {1'b0, quo_host};

  // Build the result and the updated statistics.
  logic [31:0] seq_n;
  logic        seq_gt1;
  logic        flag_empty, flag_below, flag_late;
  logic [47:0] gap_full;
  logic [NUM_W-1:0] exp_full;
  logic [31:0] gap_sat;
  logic [15:0] dl, dr, step;
  logic        frames_nz;

  always_comb begin
    seq_n      = submit_q + 32'd1;
    seq_gt1    = |seq_n[31:1];
    flag_empty = seq_gt1 && (item_q.fill_before == 16'd0);
    flag_below = seq_gt1 && (item_q.fill_before < host_q);
    gap_full   = meas_q ? gap_q : 48'd0;
    exp_full   = meas_q ? quo_exp : '0;
    flag_late  = meas_q && (gap_q > 48'(sum_q));
    gap_sat    = (|gap_full[47:32]) ? 32'hFFFF_FFFF : gap_full[31:0];
    frames_nz  = item_q.frame_count != 16'd0;
    dl         = abs_diff(item_q.first_left, tail_left_q);
    dr         = abs_diff(item_q.first_right, tail_right_q);
    step       = (tail_valid_q && frames_nz) ? ((dl > dr) ? dl : dr) : 16'd0;

    out_d = out_q;
    out_d.sequence_res             = seq_n;
    out_d.status_flags             = '0;
    out_d.status_flags[FLAG_EMPTY] = flag_empty;
    out_d.status_flags[FLAG_BELOW] = flag_below;
    out_d.status_flags[FLAG_LATE]  = flag_late;
    out_d.gap_us                   = gap_sat;
    out_d.expected_us              = (|exp_full[NUM_W-1:23]) ? 23'h7F_FFFF : exp_full[22:0];
    out_d.seam_step                = step;
    out_d.empty_total   = (flag_empty && empty_cnt_q != 32'hFFFF_FFFF) ?
                          empty_cnt_q + 32'd1 : empty_cnt_q;
    out_d.below_total   = (flag_below && below_cnt_q != 32'hFFFF_FFFF) ?
                          below_cnt_q + 32'd1 : below_cnt_q;
    out_d.late_total    = (flag_late && late_cnt_q != 32'hFFFF_FFFF) ?
                          late_cnt_q + 32'd1 : late_cnt_q;
    out_d.fill_min      = (item_q.fill_before < min_fill_q) ? item_q.fill_before : min_fill_q;
    out_d.fill_max      = (item_q.fill_before > max_fill_q) ? item_q.fill_before : max_fill_q;
    out_d.gap_max       = (gap_sat > max_gap_q) ? gap_sat : max_gap_q;
    out_d.seam_step_max = (step > max_step_q) ? step : max_step_q;
  end

  // Control and running state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      rate_q       <= RATE_RESET;
      host_q       <= HOST_RESET;
      submit_q     <= '0;
      last_fc_q    <= '0;
      last_time_q  <= '0;
      time_valid_q <= 1'b0;
      tail_left_q  <= '0;
      tail_right_q <= '0;
      tail_valid_q <= 1'b0;
      empty_cnt_q  <= '0;
      below_cnt_q  <= '0;
      late_cnt_q   <= '0;
      min_fill_q   <= 16'hFFFF;
      max_fill_q   <= '0;
      max_gap_q    <= '0;
      max_step_q   <= '0;
    end else begin
      state_q <= state_d;

      // Decode configuration writes; drop unknown indexes.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SAMPLE_RATE: rate_q <= cfg_data_i;
          CFG_HOST_PERIOD: host_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // Release the result once taken, reload it at the finish step.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Commit the request to the running state.
      if (out_load) begin
        submit_q     <= seq_n;
        last_fc_q    <= item_q.frame_count;
        last_time_q  <= item_q.time_us;
        time_valid_q <= 1'b1;
        if (frames_nz) begin
          tail_left_q  <= item_q.last_left;
          tail_right_q <= item_q.last_right;
          tail_valid_q <= 1'b1;
        end
        empty_cnt_q <= out_d.empty_total;
        below_cnt_q <= out_d.below_total;
        late_cnt_q  <= out_d.late_total;
        min_fill_q  <= out_d.fill_min;
        max_fill_q  <= out_d.fill_max;
        max_gap_q   <= out_d.gap_max;
        max_step_q  <= out_d.seam_step_max;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
      gap_q  <= in_data_i.time_us - last_time_q;
      meas_q <= time_valid_q && (rate_q != 18'd0);
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/aqhm_checker.sv */
// Port-level checker of the audio queue health monitor, with its bind.
`default_nettype none

`include "audio_queue_health_monitor_unit_macros.svh"

module aqhm_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_ready_o,
  input wire                            out_valid_o,
  input wire                            out_ready_i,
  input aqhm_pkg::out_t                 out_data_o
);
  import aqhm_pkg::*;

  // A taken request closes the input behind it.
  `AQHM_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A stalled result stays and holds its value.
  `AQHM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // A late submit always has a nonzero gap.
  `AQHM_ASSERT_NOW(a_late_gap, clk_i, rst_ni, out_valid_o && out_data_o.status_flags[FLAG_LATE], out_data_o.gap_us != 32'd0)

  // Fill extremes are ordered once any result exists.
  `AQHM_ASSERT_NOW(a_fill_order, clk_i, rst_ni, out_valid_o, out_data_o.fill_min <= out_data_o.fill_max)

endmodule

bind audio_queue_health_monitor_unit aqhm_checker u_aqhm_checker (.*);

`default_nettype wire

/* tb/aqhm_tb_pkg.sv */
// Scoreboard of the audio queue health monitor testbench: predictor and result checks.
`timescale 1ns / 100ps

package aqhm_tb_pkg;

  import aqhm_pkg::*;

  localparam longint unsigned US_PER_SEC   = 64'd1000000;

  class aqhm_scoreboard;

    // Register copies
    bit [17:0] rate_fps;
    bit [15:0] host_frames;

    // Monitor state as seen by the predictor
    bit [31:0]        submit_count;
    bit [15:0]        prev_frames;
    bit [47:0]        prev_time;
    bit               prev_time_ok;
    bit signed [15:0] tail_left;
    bit signed [15:0] tail_right;
    bit               tail_ok;
    bit [31:0]        empty_count;
    bit [31:0]        below_count;
    bit [31:0]        late_count;
    bit [15:0]        fill_low;
    bit [15:0]        fill_high;
    bit [31:0]        gap_high;
    bit [15:0]        step_high;

    out_t pending_health[$];
    int   mismatches;
    int   results_seen;
    int   requests_seen;

    function new();
      rate_fps    = RATE_RESET;
      host_frames = HOST_RESET;
      fill_low    = '1;
    endfunction

    // Mirror a register write; unknown indexes change nothing
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SAMPLE_RATE: rate_fps = data;
        CFG_HOST_PERIOD: host_frames = data[15:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] bump(bit [31:0] cnt, bit hit);
      return (hit && cnt != '1) ? cnt + 32'd1 : cnt;
    endfunction

    // Advance the monitor state by one request and build its health record
    function out_t predict_health(in_t req);
      out_t            res;
      bit              empty_hit;
      bit              below_hit;
      bit              late_hit;
      bit [47:0]       delta;
      longint unsigned gap_full;
      longint unsigned play_us;
      longint unsigned host_us;
      bit [31:0]       gap_sat;
      bit [15:0]       step;
      int              dl;
      int              dr;

      submit_count = submit_count + 32'd1;
      empty_hit = (submit_count > 1) && (req.fill_before == 16'd0);
      below_hit = (submit_count > 1) && (req.fill_before < host_frames);

      gap_full = 0;
      play_us  = 0;
      late_hit = 1'b0;
      step     = '0;
      if (prev_time_ok && rate_fps != 0) begin
        delta    = req.time_us - prev_time;
        gap_full = 64'(delta);
        play_us  = 64'(prev_frames) * US_PER_SEC / 64'(rate_fps);
        host_us  = 64'(host_frames) * US_PER_SEC / 64'(rate_fps);
        late_hit = gap_full > play_us + host_us;
      end
      gap_sat = (gap_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap_full[31:0];

      // Seam step against the last frame of the previous non-empty buffer
      if (tail_ok && req.frame_count != 16'd0) begin
        dl = int'(req.first_left) - int'(tail_left);
        dr = int'(req.first_right) - int'(tail_right);
        if (dl < 0) dl = -dl;
        if (dr < 0) dr = -dr;
        step = (dl > dr) ? 16'(dl) : 16'(dr);
      end
      if (req.frame_count != 16'd0) begin
        tail_left  = req.last_left;
        tail_right = req.last_right;
        tail_ok    = 1'b1;
      end
      prev_frames  = req.frame_count;
      prev_time    = req.time_us;
      prev_time_ok = 1'b1;

      empty_count = bump(empty_count, empty_hit);
      below_count = bump(below_count, below_hit);
      late_count  = bump(late_count, late_hit);
      if (req.fill_before < fill_low) fill_low = req.fill_before;
      if (req.fill_before > fill_high) fill_high = req.fill_before;
      if (gap_sat > gap_high) gap_high = gap_sat;
      if (step > step_high) step_high = step;

      res = '0;
      res.sequence_res             = submit_count;
      res.status_flags[FLAG_EMPTY] = empty_hit;
      res.status_flags[FLAG_BELOW] = below_hit;
      res.status_flags[FLAG_LATE]  = late_hit;
      res.gap_us                   = gap_sat;
      res.expected_us              = (play_us > 64'h7F_FFFF) ? 23'h7F_FFFF : play_us[22:0];
      res.seam_step                = step;
      res.empty_total              = empty_count;
      res.below_total              = below_count;
      res.late_total               = late_count;
      res.fill_min                 = fill_low;
      res.fill_max                 = fill_high;
      res.gap_max                  = gap_high;
      res.seam_step_max            = step_high;
      return res;
    endfunction

    // Note an accepted request and queue its expected health record
    function void note_request(in_t req);
      pending_health.push_back(predict_health(req));
      requests_seen++;
    endfunction

    function int pending_count();
      return pending_health.size();
    endfunction

    // Print one line per mismatch and count it
    task report(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want, int unsigned seq);
      if (got !== want)
        report($sformatf("seq %0d %s: got 0x%0h, expected 0x%0h", seq, name, got, want));
    endtask

    // Check an accepted result against the oldest expected record
    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (pending_health.size() == 0) begin
        report($sformatf("result seq %0d with no request outstanding", got.sequence_res));
        return;
      end
      want = pending_health.pop_front();
      compare_field("sequence_res", got.sequence_res, want.sequence_res, want.sequence_res);
      compare_field("status_flags", got.status_flags, want.status_flags, want.sequence_res);
      compare_field("gap_us", got.gap_us, want.gap_us, want.sequence_res);
      compare_field("expected_us", got.expected_us, want.expected_us, want.sequence_res);
      compare_field("seam_step", got.seam_step, want.seam_step, want.sequence_res);
      compare_field("empty_total", got.empty_total, want.empty_total, want.sequence_res);
      compare_field("below_total", got.below_total, want.below_total, want.sequence_res);
      compare_field("late_total", got.late_total, want.late_total, want.sequence_res);
      compare_field("fill_min", got.fill_min, want.fill_min, want.sequence_res);
      compare_field("fill_max", got.fill_max, want.fill_max, want.sequence_res);
      compare_field("gap_max", got.gap_max, want.gap_max, want.sequence_res);
      compare_field("seam_step_max", got.seam_step_max, want.seam_step_max, want.sequence_res);
    endtask

  endclass

endpackage

/* tb/tb_top.sv */
// Top level of the audio queue health monitor testbench: stimulus, sink and watchdog.
`timescale 1ns / 100ps

module tb_top;

  import aqhm_pkg::*;
  import aqhm_tb_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 167;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 48;
  localparam int WATCHDOG_LIMIT  = 4000;

  // Indexes past the two defined registers
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int PHASE_RATE [NUM_PHASES] = '{44100, 8000, 192000, 0, 1, 262143, 96000, 48000};
  localparam int PHASE_HOST [NUM_PHASES] = '{1024, 0, 65535, 256, 100, 65535, 480, 512};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  aqhm_scoreboard book;
  bit             burst_mode;
  bit             hold_off_req;
  int             idle_cycles;

  // Sender-side view of the stream, used to shape plausible timestamps and seams
  logic [47:0]        stim_time;
  logic [15:0]        stim_frames;
  logic signed [15:0] stim_tail_l;
  logic signed [15:0] stim_tail_r;

  audio_queue_health_monitor_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run when no request or result moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("audio_queue_health_monitor_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones, none in burst stretches
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t make_request(logic [15:0] fill, logic [15:0] frames,
                                       logic [15:0] fl, logic [15:0] fr,
                                       logic [15:0] ll, logic [15:0] lr, logic [47:0] t);
    in_t req;
    req.fill_before = fill;
    req.frame_count = frames;
    req.first_left  = fl;
    req.first_right = fr;
    req.last_left   = ll;
    req.last_right  = lr;
    req.time_us     = t;
    return req;
  endfunction

  // Mostly a small step from a neighbor sample, sometimes anything or a rail
  function automatic logic [15:0] pick_sample(logic [15:0] near);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return near + 16'($urandom_range(0, 64)) - 16'd32;
    if (r < 85) return 16'($urandom);
    if (r < 90) return 16'h7FFF;
    if (r < 95) return 16'h8000;
    if (r < 98) return 16'h0000;
    return 16'hFFFF;
  endfunction

  // Build a submission that lands near the on-time and late boundaries
  function automatic in_t random_request();
    in_t             req;
    longint unsigned nominal;
    longint unsigned host_us;
    longint unsigned span;
    longint unsigned delta;
    longint unsigned stamp;
    int              r;
    int              fill_lim;

    if (book.rate_fps == 0) begin
      nominal = 10000;
      host_us = 2000;
    end else begin
      nominal = 64'(stim_frames) * US_PER_SEC / 64'(book.rate_fps);
      host_us = 64'(book.host_frames) * US_PER_SEC / 64'(book.rate_fps);
    end
    span = (2 * host_us > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : 2 * host_us;

    r = $urandom_range(0, 99);
    if (r < 50)      delta = nominal + $urandom_range(0, span[31:0]);
    else if (r < 58) delta = nominal + host_us;
    else if (r < 63) delta = nominal + host_us + 1;
    else if (r < 75) delta = (nominal > 500) ? nominal - $urandom_range(0, 500) : 0;
    else if (r < 85) delta = $urandom_range(0, 3000);
    else if (r < 93) delta = {$urandom, $urandom};
    else             delta = 64'h1_0000_0000 + 64'($urandom);
    stamp = 64'(stim_time) + delta;
    req.time_us = stamp[47:0];

    fill_lim = 2 * int'(book.host_frames) + 16;
    if (fill_lim > 65535) fill_lim = 65535;
    r = $urandom_range(0, 99);
    if (r < 8)       req.fill_before = '0;
    else if (r < 13) req.fill_before = '1;
    else if (r < 25) req.fill_before = book.host_frames + 16'($urandom_range(0, 2)) - 16'd1;
    else if (r < 40) req.fill_before = 16'($urandom);
    else             req.fill_before = 16'($urandom_range(0, fill_lim));

    r = $urandom_range(0, 99);
    if (r < 10)      req.frame_count = '0;
    else if (r < 15) req.frame_count = '1;
    else if (r < 28) req.frame_count = 16'($urandom);
    else             req.frame_count = 16'($urandom_range(32, 4096));

    req.first_left  = pick_sample(stim_tail_l);
    req.first_right = pick_sample(stim_tail_r);
    req.last_left   = pick_sample(req.first_left);
    req.last_right  = pick_sample(req.first_right);
    return req;
  endfunction

  // Offer one request, hold it until accepted, then note it
  task automatic send_request(in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    book.note_request(req);
    stim_time   = req.time_us;
    stim_frames = req.frame_count;
    if (req.frame_count != 16'd0) begin
      stim_tail_l = req.last_left;
      stim_tail_r = req.last_right;
    end
    @(negedge clk);
  endtask

  // Hold the sender until every expected record has come, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    book.write_register(idx, data);
    @(negedge clk);
  endtask

  // Program both registers, optionally poke the undefined indexes too
  task automatic apply_setting(int rate, int host, bit spare);
    write_register(CFG_SAMPLE_RATE, CFG_DATA_W'(rate));
    if (spare) begin
      write_register(CFG_SPARE_LO, CFG_DATA_W'($urandom));
      write_register(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    end
    write_register(CFG_HOST_PERIOD, CFG_DATA_W'(host));
    cfg_we <= 1'b0;
  endtask

  // Result sink: random back-pressure, one long hold-off on request
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      book.check_result(out_data);
    end
  end

  initial begin : stimulus
    book        = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    stim_time   = '0;
    stim_frames = '0;
    stim_tail_l = '0;
    stim_tail_r = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed submissions at reset settings (48 kHz, 512-frame period)
    send_request(make_request(16'd0, 16'd480, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 48'd1000));
    send_request(make_request(16'd0, 16'd480, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 48'd11000));
    // empty buffer, gap exactly on the late threshold
    send_request(make_request(16'd511, 16'd0, 16'h04D2, 16'hFB2E, 16'h0063, 16'h0063, 48'd31666));
    // one past the threshold after an empty buffer
    send_request(make_request(16'd512, 16'd480, 16'h0005, 16'hFFF9, 16'h0064, 16'hFF9C, 48'd42333));
    send_request(make_request(16'hFFFF, 16'hFFFF, 16'h0064, 16'hFF9C, 16'hFFFF, 16'hFFFF,
                              48'd42334));
    // gap beyond 32 bits
    send_request(make_request(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA,
                              48'd42334 + 48'h100_0000_0000));
    // timestamp wrap
    send_request(make_request(16'd513, 16'd480, 16'h5555, 16'hAAAA, 16'h1234, 16'hEDCC,
                              48'hFFFF_FFFF_FFF0));
    send_request(make_request(16'd514, 16'd480, 16'h1230, 16'hEDD0, 16'h0000, 16'h0000, 48'd5));
    send_request(make_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              48'hFFFF_FFFF_FFFF));
    send_request(make_request(16'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 48'd0));
    send_request(make_request(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555,
                              48'h5555_5555_5555));
    send_request(make_request(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                              48'hAAAA_AAAA_AAAA));
    send_request(make_request(16'd100, 16'd480, 16'hAAA0, 16'hAAB0, 16'h0010, 16'hFFF0,
                              48'hAAAA_AAAA_AAAA));
    send_request(make_request(16'd1000, 16'd480, 16'h0011, 16'hFFEF, 16'h0000, 16'h0000,
                              48'hAAAA_AAAA_AAAA + 48'd10000));
    wait_drained();

    // Random phases over a sweep of register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(PHASE_RATE[p], PHASE_HOST[p], p == 0 || p == 3);
      burst_mode = (p == 1 || p == 6);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == 40) hold_off_req = 1'b1;
        if (p == 4 && i == 80) wait_drained();
        send_request(random_request());
      end
      wait_drained();
    end

    $display("covered %0d submissions, %0d results, %0d register settings incl. zero rate",
             book.requests_seen, book.results_seen, NUM_PHASES + 1);
    $display("recorded %0d mismatches", book.mismatches);
    if (book.mismatches == 0) begin
      $display("audio_queue_health_monitor_unit regression: pass");
    end else begin
      $display("audio_queue_health_monitor_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/aqhm_pkg.sv
hdl/aqhm_serial_div.sv
hdl/audio_queue_health_monitor_unit.sv
hdl/aqhm_checker.sv
tb/aqhm_tb_pkg.sv
tb/tb_top.sv
